// File: hdl/ppvc_pkg.sv
// Shared widths and constants for the pure pursuit velocity command block.
// Holds the CORDIC arctangent table and the Q30 angle constants.
// No dependencies.
package ppvc_pkg;

   localparam int PW    = 24;  // waypoint and pose coordinate width
   localparam int DXW   = 25;  // coordinate difference width
   localparam int SQW   = 48;  // width of one squared difference
   localparam int D2W   = 50;  // width of a squared distance
   localparam int RTW   = 25;  // width of a distance
   localparam int DISTW = 23;  // width of the distance registers
   localparam int SPW   = 16;  // speed width
   localparam int NUMW  = SPW + DISTW;
   localparam int CXW   = 58;  // vectoring CORDIC datapath width
   localparam int AGW   = 35;  // Q30 angle width
   localparam int SCW   = 34;  // rotation CORDIC datapath width
   localparam int PRW   = 51;  // velocity product width
   localparam int VW    = 17;  // velocity width
   localparam int YAWW  = 16;
   localparam int ITW   = 5;
   localparam int ATAN_ENTRIES = 24;

   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_APPEND  = 2'd1;
   localparam logic [1:0] MODE_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_AHEAD = 2'd0;
   localparam logic [1:0] CSR_MAXSP = 2'd1;
   localparam logic [1:0] CSR_STOP  = 2'd2;
   localparam logic [1:0] CSR_SLOW  = 2'd3;

   localparam logic signed [AGW-1:0] Q_PI       = 35'sd3373259426;
   localparam logic signed [AGW-1:0] Q_HALF_PI  = 35'sd1686629713;
   localparam logic signed [AGW-1:0] Q_TWO_PI   = 35'sd6746518852;
   localparam logic signed [SCW-1:0] Q_INV_GAIN = 34'sd652032874;

   function automatic logic [29:0] atan_q30(input logic [ITW-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/pure_pursuit_velocity_command_top.sv
// Top level of the pure pursuit velocity command block: sequencer, waypoint RAM,
// scan pipeline and CORDIC. Depends on ppvc_pkg, ppvc_ram, ppvc_sqrt, ppvc_div.
//
// Request transactions carry a mode. A clear or append transaction gives no
// response. A compute transaction gives one response transaction with speed,
// vel_x, vel_y, target_index and status.
// A compute on an empty path responds with status set.
// Otherwise the waypoints are streamed out of the RAM one per cycle through a
// three-stage distance pipeline, then the target waypoint is read back, and an
// iterative square root, a divider (only when the speed ramp needs it) and a
// CORDIC stage (atan2, then sin and cos, sharing the arctangent table) run in turn.
// A new request is taken only while the sequencer is idle. A finished response
// waits in the output register while the receiver stalls, and the next request
// can be taken as soon as the response is registered. Reset empties the path and
// clears all configuration registers to zero. The waypoint RAM is not cleared;
// entries are only read below the path length. Configuration writes take effect at
// once; the user must make them while the block is idle; the block does not check.
module pure_pursuit_velocity_command_top
   import ppvc_pkg::*;
#(
   parameter int MAX_POINTS   = 256,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic signed [PW-1:0]  req_point_x,
   input  logic signed [PW-1:0]  req_point_y,
   input  logic signed [PW-1:0]  req_robot_x,
   input  logic signed [PW-1:0]  req_robot_y,
   input  logic signed [YAWW-1:0] req_robot_yaw,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SPW-1:0]        rsp_speed,
   output logic signed [VW-1:0]  rsp_vel_x,
   output logic signed [VW-1:0]  rsp_vel_y,
   output logic [7:0]            rsp_target_index,
   output logic                  rsp_status,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [DISTW-1:0]      csr_wdata
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int SW    = ((AW > 8) ? AW : 8) + 1;
   localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCAN, ST_TGT_RD, ST_TGT_LD, ST_SQRT, ST_SPD, ST_DIVST, ST_DIV,
      ST_AT, ST_AT_IT, ST_ANG, ST_WRAP, ST_FOLD, ST_SC_IT, ST_VX, ST_VY, ST_VEND,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]       ahead_ff;
   logic [SPW-1:0]   maxsp_ff;
   logic [DISTW-1:0] stop_ff, slow_ff;

   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic signed [PW-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic signed [YAWW-1:0] yaw_ff, yaw_in;

   logic             p0_vld_ff, p0_vld_in, p1_vld_ff, p1_vld_in, p2_vld_ff, p2_vld_in;
   logic [AW-1:0]    p0_idx_ff, p0_idx_in, p1_idx_ff, p1_idx_in, p2_idx_ff, p2_idx_in;
   logic signed [DXW-1:0] p1_dx_ff, p1_dx_in, p1_dy_ff, p1_dy_in;
   logic [SQW-1:0]   p2_sx_ff, p2_sx_in, p2_sy_ff, p2_sy_in;
   logic signed [2*DXW-1:0] sqx, sqy;
   logic [D2W-1:0]   d2;
   logic [D2W-1:0]   best_ff, best_in, last_ff, last_in;
   logic [AW-1:0]    near_ff, near_in, tgt_ff, tgt_in;
   logic [SW-1:0]    tsum;
   logic signed [DXW-1:0] tdx_ff, tdx_in, tdy_ff, tdy_in;

   logic [RTW-1:0]   d_ff, d_in;
   logic [SPW-1:0]   speed_ff, speed_in;
   logic [NUMW-1:0]  num_ff, num_in;

   logic signed [CXW-1:0] cx_ff, cx_in, cy_ff, cy_in, cx0, cy0, cxs, cys;
   logic signed [AGW-1:0] z_ff, z_in, ang_ff, ang_in, atv;
   logic [ITW-1:0]        it_ff, it_in;
   logic                  neg_ff, neg_in;
   logic signed [SCW-1:0] sx_ff, sx_in, sy_ff, sy_in, sxs, sys, trig;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [VW:0]    spd_s;
   logic signed [VW-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic                  stat_ff, stat_in;

   logic                  rsp_valid_ff, rsp_valid_in, load;
   logic [SPW-1:0]        rsp_speed_ff;
   logic signed [VW-1:0]  rsp_vel_x_ff, rsp_vel_y_ff;
   logic [7:0]            rsp_target_index_ff;
   logic                  rsp_status_ff;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [2*PW-1:0]       mem_wdata, mem_rdata;
   logic [PW-1:0]         rd_x, rd_y;

   logic                  sqrt_start, sqrt_done, div_start, div_done;
   logic [RTW-1:0]        sqrt_root;
   logic [SPW-1:0]        div_quo;

   function automatic logic signed [VW-1:0] sat_vel(input logic signed [PRW-1:0] p);
      logic signed [PRW-1:0] t;
      t = (p + PRW'(64'sd536870912)) >>> 30;
      if (t > PRW'(64'sd65535)) begin
         return 17'sh0FFFF;
      end else if (t < -PRW'(64'sd65536)) begin
         return 17'sh10000;
      end
      return t[VW-1:0];
   endfunction

   ppvc_ram #(.WIDTH(2 * PW), .DEPTH(MAX_POINTS)) u_way_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ppvc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (last_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   ppvc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (slow_ff - stop_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rd_x       = mem_rdata[2*PW-1:PW];
   assign rd_y       = mem_rdata[PW-1:0];
   assign sqrt_start = (state_ff == ST_TGT_LD);
   assign div_start  = (state_ff == ST_DIVST);
   assign req_ready  = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         ahead_ff <= '0;
         maxsp_ff <= '0;
         stop_ff  <= '0;
         slow_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AHEAD: ahead_ff <= csr_wdata[7:0];
            CSR_MAXSP: maxsp_ff <= csr_wdata[SPW-1:0];
            CSR_STOP:  stop_ff  <= csr_wdata;
            CSR_SLOW:  slow_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      issue_in  = issue_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      yaw_in    = yaw_ff;
      best_in   = best_ff;
      last_in   = last_ff;
      near_in   = near_ff;
      tgt_in    = tgt_ff;
      tdx_in    = tdx_ff;
      tdy_in    = tdy_ff;
      d_in      = d_ff;
      speed_in  = speed_ff;
      num_in    = num_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      z_in      = z_ff;
      ang_in    = ang_ff;
      it_in     = it_ff;
      neg_in    = neg_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      prod_in   = prod_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      stat_in   = stat_ff;
      load      = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = {req_point_x, req_point_y};
      mem_raddr = issue_ff[AW-1:0];
      tsum      = SW'(near_ff) + SW'(ahead_ff);

      p0_vld_in = 1'b0;
      p0_idx_in = issue_ff[AW-1:0];
      p1_vld_in = p0_vld_ff;
      p1_idx_in = p0_idx_ff;
      p1_dx_in  = {rd_x[PW-1], rd_x} - {rx_ff[PW-1], rx_ff};
      p1_dy_in  = {rd_y[PW-1], rd_y} - {ry_ff[PW-1], ry_ff};
      p2_vld_in = p1_vld_ff;
      p2_idx_in = p1_idx_ff;
      sqx       = p1_dx_ff * p1_dx_ff;
      sqy       = p1_dy_ff * p1_dy_ff;
      p2_sx_in  = sqx[SQW-1:0];
      p2_sy_in  = sqy[SQW-1:0];
      d2        = D2W'(p2_sx_ff) + D2W'(p2_sy_ff);
      if (p2_vld_ff) begin
         if (p2_idx_ff == '0 || d2 < best_ff) begin
            best_in = d2;
            near_in = p2_idx_ff;
         end
         if (p2_idx_ff == AW'(count_ff - 1'b1)) begin
            last_in = d2;
         end
      end

      cx0  = {{(CXW - DXW - 30){tdx_ff[DXW-1]}}, tdx_ff, 30'b0};
      cy0  = {{(CXW - DXW - 30){tdy_ff[DXW-1]}}, tdy_ff, 30'b0};
      cxs  = cx_ff >>> it_ff;
      cys  = cy_ff >>> it_ff;
      sxs  = sx_ff >>> it_ff;
      sys  = sy_ff >>> it_ff;
      atv  = AGW'(atan_q30(it_ff));
      spd_s = {2'b00, speed_ff};
      trig = neg_ff ? -sx_ff : sx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_CLEAR: count_in = '0;
                  MODE_APPEND: begin
                     if (count_ff < CW'(MAX_POINTS)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_COMPUTE: begin
                     if (count_ff == '0) begin
                        speed_in = '0;
                        vx_in    = '0;
                        vy_in    = '0;
                        tgt_in   = '0;
                        stat_in  = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        rx_in    = req_robot_x;
                        ry_in    = req_robot_y;
                        yaw_in   = req_robot_yaw;
                        issue_in = '0;
                        stat_in  = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               p0_vld_in = 1'b1;
               issue_in  = issue_ff + 1'b1;
            end else if (!p0_vld_ff && !p1_vld_ff && !p2_vld_ff) begin
               state_in = ST_TGT_RD;
            end
         end
         ST_TGT_RD: begin
            if (tsum < SW'(count_ff)) begin
               tgt_in = AW'(tsum);
            end else begin
               tgt_in = AW'(count_ff - 1'b1);
            end
            mem_raddr = tgt_in;
            state_in  = ST_TGT_LD;
         end
         ST_TGT_LD: begin
            tdx_in   = p1_dx_in;
            tdy_in   = p1_dy_in;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               d_in     = sqrt_root;
               state_in = ST_SPD;
            end
         end
         ST_SPD: begin
            if (d_ff < RTW'(stop_ff)) begin
               speed_in = '0;
               state_in = ST_AT;
            end else if (d_ff < RTW'(slow_ff)) begin
               num_in   = maxsp_ff * (d_ff[DISTW-1:0] - stop_ff);
               state_in = ST_DIVST;
            end else begin
               speed_in = maxsp_ff;
               state_in = ST_AT;
            end
         end
         ST_DIVST: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               speed_in = div_quo;
               state_in = ST_AT;
            end
         end
         ST_AT: begin
            it_in = '0;
            if (tdx_ff == '0 && tdy_ff == '0) begin
               z_in     = '0;
               state_in = ST_ANG;
            end else begin
               state_in = ST_AT_IT;
               if (tdx_ff[DXW-1]) begin
                  if (!tdy_ff[DXW-1]) begin
                     cx_in = cy0;
                     cy_in = -cx0;
                     z_in  = Q_HALF_PI;
                  end else begin
                     cx_in = -cy0;
                     cy_in = cx0;
                     z_in  = -Q_HALF_PI;
                  end
               end else begin
                  cx_in = cx0;
                  cy_in = cy0;
                  z_in  = '0;
               end
            end
         end
         ST_AT_IT: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + cys;
               cy_in = cy_ff - cxs;
               z_in  = z_ff + atv;
            end else begin
               cx_in = cx_ff - cys;
               cy_in = cy_ff + cxs;
               z_in  = z_ff - atv;
            end
            it_in = it_ff + 1'b1;
            if (it_ff == ITW'(NSTEP - 1)) begin
               state_in = ST_ANG;
            end
         end
         ST_ANG: begin
            ang_in   = z_ff - {{(AGW - YAWW - 17){yaw_ff[YAWW-1]}}, yaw_ff, 17'b0};
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (ang_ff > Q_PI) begin
               ang_in = ang_ff - Q_TWO_PI;
            end else if (ang_ff < -Q_PI) begin
               ang_in = ang_ff + Q_TWO_PI;
            end
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            neg_in = 1'b0;
            if (ang_ff > Q_HALF_PI) begin
               ang_in = ang_ff - Q_PI;
               neg_in = 1'b1;
            end else if (ang_ff < -Q_HALF_PI) begin
               ang_in = ang_ff + Q_PI;
               neg_in = 1'b1;
            end
            sx_in    = Q_INV_GAIN;
            sy_in    = '0;
            it_in    = '0;
            state_in = ST_SC_IT;
         end
         ST_SC_IT: begin
            if (!ang_ff[AGW-1]) begin
               sx_in  = sx_ff - sys;
               sy_in  = sy_ff + sxs;
               ang_in = ang_ff - atv;
            end else begin
               sx_in  = sx_ff + sys;
               sy_in  = sy_ff - sxs;
               ang_in = ang_ff + atv;
            end
            it_in = it_ff + 1'b1;
            if (it_ff == ITW'(NSTEP - 1)) begin
               state_in = ST_VX;
            end
         end
         ST_VX: begin
            prod_in  = spd_s * trig;
            state_in = ST_VY;
         end
         ST_VY: begin
            vx_in    = sat_vel(prod_ff);
            prod_in  = spd_s * (neg_ff ? -sy_ff : sy_ff);
            state_in = ST_VEND;
         end
         ST_VEND: begin
            vy_in    = sat_vel(prod_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         p0_vld_ff    <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         p0_vld_ff    <= p0_vld_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff  <= issue_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      yaw_ff    <= yaw_in;
      p0_idx_ff <= p0_idx_in;
      p1_idx_ff <= p1_idx_in;
      p1_dx_ff  <= p1_dx_in;
      p1_dy_ff  <= p1_dy_in;
      p2_idx_ff <= p2_idx_in;
      p2_sx_ff  <= p2_sx_in;
      p2_sy_ff  <= p2_sy_in;
      best_ff   <= best_in;
      last_ff   <= last_in;
      near_ff   <= near_in;
      tgt_ff    <= tgt_in;
      tdx_ff    <= tdx_in;
      tdy_ff    <= tdy_in;
      d_ff      <= d_in;
      speed_ff  <= speed_in;
      num_ff    <= num_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      z_ff      <= z_in;
      ang_ff    <= ang_in;
      it_ff     <= it_in;
      neg_ff    <= neg_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      prod_ff   <= prod_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      stat_ff   <= stat_in;
      if (load) begin
         rsp_speed_ff        <= speed_ff;
         rsp_vel_x_ff        <= vx_ff;
         rsp_vel_y_ff        <= vy_ff;
         rsp_target_index_ff <= 8'(tgt_ff);
         rsp_status_ff       <= stat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_speed        = rsp_speed_ff;
   assign rsp_vel_x        = rsp_vel_x_ff;
   assign rsp_vel_y        = rsp_vel_y_ff;
   assign rsp_target_index = rsp_target_index_ff;
   assign rsp_status       = rsp_status_ff;

   // The path never grows past its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("path length exceeds capacity");

   // An empty-path response carries zero speed and target.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_speed_ff == '0 && rsp_target_index_ff == '0))
      else $error("empty path response is not zero");

   // A new response is only registered by the final sequencer state.
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      (load) |-> (state_ff == ST_DONE && state_in == ST_IDLE))
      else $error("response loaded outside completion");

endmodule

// File: hdl/ppvc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ppvc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/ppvc_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on ppvc_pkg for the operand and root widths.
module ppvc_sqrt
   import ppvc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [D2W-1:0] radicand,
   output logic           done,
   output logic [RTW-1:0] root
);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [D2W-1:0] n_ff, n_in;
   logic [D2W-1:0] r_ff, r_in;
   logic [D2W-1:0] bit_ff, bit_in;
   logic [D2W-1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      trial   = r_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         n_in    = radicand;
         r_in    = '0;
         bit_in  = D2W'(1) << (D2W - 2);
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == D2W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[RTW-1:0];

endmodule

// File: hdl/ppvc_div.sv
// Restoring divider for the speed ramp, one quotient bit per cycle.
// The quotient is known to fit in SPW bits. Depends on ppvc_pkg.
module ppvc_div
   import ppvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUMW-1:0]  num,
   input  logic [DISTW-1:0] den,
   output logic             done,
   output logic [SPW-1:0]   quo
);

   localparam int CNTW = $clog2(SPW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [DISTW-1:0] rem_ff, rem_in;
   logic [DISTW-1:0] den_ff, den_in;
   logic [SPW-1:0]   low_ff, low_in;
   logic [SPW-1:0]   q_ff, q_in;
   logic [DISTW:0]   rem2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      rem2    = {rem_ff, low_ff[SPW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num[NUMW-1:SPW];
         low_in  = num[SPW-1:0];
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         low_in = low_ff << 1;
         if (rem2 >= {1'b0, den_ff}) begin
            rem_in = DISTW'(rem2 - {1'b0, den_ff});
            q_in   = {q_ff[SPW-2:0], 1'b1};
         end else begin
            rem_in = rem2[DISTW-1:0];
            q_in   = {q_ff[SPW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(SPW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

// File: dv/tb_pure_pursuit_velocity_command_top.sv
// Self-checking testbench for pure_pursuit_velocity_command_top: predicts each
// velocity command from its own path model and compares it with the response channel.
// Depends on ppvc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_pure_pursuit_velocity_command_top;
   import ppvc_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int     PATH_DEPTH   = 256;
   localparam int     ITERATIONS   = 16;
   localparam int     SETTLE       = 400;
   localparam longint CYCLE_LIMIT  = 4000000;
   localparam longint ANG_PI       = 64'sd3373259426;
   localparam longint ANG_HALF_PI  = 64'sd1686629713;
   localparam longint ANG_TWO_PI   = 64'sd6746518852;
   localparam longint ROT_START    = 64'sd652032874;
   localparam longint ARCTAN [24]  = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
      8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128};

   typedef struct {
      logic [15:0]        speed;
      logic signed [16:0] vel_x;
      logic signed [16:0] vel_y;
      logic [7:0]         target;
      logic               status;
   } command_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_mode;
   logic signed [PW-1:0]   req_point_x;
   logic signed [PW-1:0]   req_point_y;
   logic signed [PW-1:0]   req_robot_x;
   logic signed [PW-1:0]   req_robot_y;
   logic signed [YAWW-1:0] req_robot_yaw;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SPW-1:0]         rsp_speed;
   logic signed [VW-1:0]   rsp_vel_x;
   logic signed [VW-1:0]   rsp_vel_y;
   logic [7:0]             rsp_target_index;
   logic                   rsp_status;
   logic                   csr_we;
   logic [1:0]             csr_index;
   logic [DISTW-1:0]       csr_wdata;

   longint      path_x [PATH_DEPTH];
   longint      path_y [PATH_DEPTH];
   int          path_len;
   longint      lookahead, cruise_speed, stop_dist, slow_dist;
   command_type pending_cmds [$];
   command_type head_cmd;
   int          errors, items_sent, cmds_checked, config_writes;
   int          send_idle, recv_idle, hold_left;
   longint      cycles;

   pure_pursuit_velocity_command_top DUT (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout with %0d commands outstanding.", pending_cmds.size());
         $display("pure_pursuit_velocity_command_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            head_cmd = pending_cmds.pop_front();
            cmds_checked++;
            if (rsp_speed !== head_cmd.speed)
               report_mismatch("speed", rsp_speed, head_cmd.speed);
            if (rsp_vel_x !== head_cmd.vel_x)
               report_mismatch("vel_x", rsp_vel_x, head_cmd.vel_x);
            if (rsp_vel_y !== head_cmd.vel_y)
               report_mismatch("vel_y", rsp_vel_y, head_cmd.vel_y);
            if (rsp_target_index !== head_cmd.target)
               report_mismatch("target_index", rsp_target_index, head_cmd.target);
            if (rsp_status !== head_cmd.status)
               report_mismatch("status", rsp_status, head_cmd.status);
         end
      end
   end

   function automatic longint int_sqrt(input longint n);
      longint r, bit_val;
      r = 0;
      bit_val = 64'sd1 << 62;
      while (bit_val > n) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (n >= r + bit_val) begin
            n = n - (r + bit_val);
            r = (r >> 1) + bit_val;
         end else begin
            r = r >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return r;
   endfunction

   function automatic longint heading_angle(input longint dy, input longint dx);
      longint x, y, z, t;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 1073741824;
      y = dy * 1073741824;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = ANG_HALF_PI;
         end else begin
            x = -y; y = t; z = -ANG_HALF_PI;
         end
      end
      for (int i = 0; i < ITERATIONS && i < 24; i++) begin
         t = x;
         if (y > 0) begin
            x = x + (y >>> i); y = y - (t >>> i); z = z + ARCTAN[i];
         end else begin
            x = x - (y >>> i); y = y + (t >>> i); z = z - ARCTAN[i];
         end
      end
      return z;
   endfunction

   task automatic rotate_unit(input longint a, output longint c, output longint s);
      longint x, y, t;
      bit flip;
      x = ROT_START;
      y = 0;
      flip = 0;
      while (a > ANG_PI) a = a - ANG_TWO_PI;
      while (a < -ANG_PI) a = a + ANG_TWO_PI;
      if (a > ANG_HALF_PI) begin
         a = a - ANG_PI; flip = 1;
      end else if (a < -ANG_HALF_PI) begin
         a = a + ANG_PI; flip = 1;
      end
      for (int i = 0; i < ITERATIONS && i < 24; i++) begin
         t = x;
         if (a >= 0) begin
            x = x - (y >>> i); y = y + (t >>> i); a = a - ARCTAN[i];
         end else begin
            x = x + (y >>> i); y = y - (t >>> i); a = a + ARCTAN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [16:0] scale_speed(input longint spd, input longint trig);
      longint v;
      v = (spd * trig + (64'sd1 << 29)) >>> 30;
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
      return v[16:0];
   endfunction

   task automatic predict_command(input logic [1:0] mode, input logic signed [23:0] px, py,
                                  input logic signed [23:0] rx, ry,
                                  input logic signed [15:0] yaw,
                                  output bit has_cmd, output command_type cmd);
      longint dx, dy, d2, best, last_gap, ang, c, s, spd;
      int nearest, target;
      has_cmd = 0;
      cmd = '{default: 0};
      best = 0;
      nearest = 0;
      case (mode)
         MODE_CLEAR: path_len = 0;
         MODE_APPEND: begin
            if (path_len < PATH_DEPTH) begin
               path_x[path_len] = px;
               path_y[path_len] = py;
               path_len++;
            end
         end
         MODE_COMPUTE: begin
            has_cmd = 1;
            if (path_len == 0) begin
               cmd.status = 1;
            end else begin
               for (int i = 0; i < path_len; i++) begin
                  dx = path_x[i] - rx;
                  dy = path_y[i] - ry;
                  d2 = dx * dx + dy * dy;
                  if (i == 0 || d2 < best) begin
                     best = d2; nearest = i;
                  end
               end
               target = int'((nearest + lookahead < path_len) ? nearest + lookahead
                                                              : path_len - 1);
               dx = path_x[path_len-1] - rx;
               dy = path_y[path_len-1] - ry;
               last_gap = int_sqrt(dx * dx + dy * dy);
               if (last_gap < stop_dist) spd = 0;
               else if (last_gap < slow_dist)
                  spd = (cruise_speed * (last_gap - stop_dist)) / (slow_dist - stop_dist);
               else spd = cruise_speed;
               ang = heading_angle(path_y[target] - ry, path_x[target] - rx)
                     - longint'(yaw) * 131072;
               rotate_unit(ang, c, s);
               cmd.speed  = spd[15:0];
               cmd.vel_x  = scale_speed(spd, c);
               cmd.vel_y  = scale_speed(spd, s);
               cmd.target = target[7:0];
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] mode, input logic signed [23:0] px, py,
                            input logic signed [23:0] rx, ry, input logic signed [15:0] yaw);
      bit has_cmd;
      command_type cmd;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_point_x   <= px;
      req_point_y   <= py;
      req_robot_x   <= rx;
      req_robot_y   <= ry;
      req_robot_yaw <= yaw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_command(mode, px, py, rx, ry, yaw, has_cmd, cmd);
      if (has_cmd) pending_cmds = {pending_cmds, cmd};
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   function automatic logic signed [23:0] any24();
      return 24'($urandom);
   endfunction

   function automatic logic signed [15:0] any16();
      return 16'($urandom);
   endfunction

   task automatic send_point(input logic signed [23:0] px, py);
      send_item(MODE_APPEND, px, py, any24(), any24(), any16());
   endtask

   task automatic send_pose(input logic signed [23:0] rx, ry, input logic signed [15:0] yaw);
      send_item(MODE_COMPUTE, any24(), any24(), rx, ry, yaw);
   endtask

   task automatic send_clear();
      send_item(MODE_CLEAR, any24(), any24(), any24(), any24(), any16());
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Call only while the block is idle.
   task automatic write_config(input longint ahead, spd, stop, slow);
      longint vals [4];
      vals = '{ahead, spd, stop, slow};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[1:0];
         csr_wdata <= vals[i][DISTW-1:0];
         @(posedge clock);
         config_writes++;
      end
      csr_we <= 1'b0;
      lookahead    = ahead & 8'hFF;
      cruise_speed = spd & 16'hFFFF;
      stop_dist    = stop & 23'h7FFFFF;
      slow_dist    = slow & 23'h7FFFFF;
   endtask

   task automatic test_directed();
      send_pose(24'sd5, -24'sd5, 16'sd0);
      send_item(MODE_UNUSED, any24(), any24(), any24(), any24(), any16());
      send_point(24'sh7FFFFF, 24'sh7FFFFF);
      send_point(-24'sh800000, -24'sh800000);
      send_point(24'sd0, 24'sd0);
      send_pose(24'sd0, 24'sd0, 16'sd0);
      send_pose(24'sh7FFFFF, -24'sh800000, 16'sh7FFF);
      send_pose(-24'sh800000, 24'sh7FFFFF, -16'sh8000);
      wait_idle();
      write_config(1, 65535, 0, 23'h7FFFFF);
      send_pose(24'sd1000, -24'sd3000, 16'sd6000);
      send_pose(-24'sh800000, -24'sh800000, -16'sd12000);
      send_clear();
      send_point(24'sd100, 24'sd0);
      send_point(-24'sd100, 24'sd0);
      send_point(24'sd0, 24'sd500);
      send_pose(24'sd0, 24'sd0, 16'sd100);
      wait_idle();
      write_config(255, 40000, 1000, 10);
      send_pose(24'sd0, 24'sd0, 16'sd0);
      send_pose(24'sd0, 24'sd200, -16'sd300);
      send_pose(24'sd0, 24'sd5000, 16'sd25000);
      send_clear();
      send_pose(24'sd7, 24'sd7, 16'sd7);
      wait_idle();
   endtask

   task automatic test_full_path();
      write_config(0, 30000, 23'h7FFFFF, 0);
      send_clear();
      for (int i = 0; i < PATH_DEPTH + 2; i++)
         send_point($signed(24'(i * 37)) - 24'sd4000, $signed(24'($urandom_range(9000))));
      send_pose(24'sd0, 24'sd0, 16'sd0);
      send_pose(24'sd6000, 24'sd3000, 16'sd9000);
      wait_idle();
      write_config(255, 65535, 0, 0);
      send_pose(-24'sd4000, 24'sd100, -16'sd4000);
      send_pose(24'sd9000, -24'sd9000, 16'sd0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      send_clear();
      for (int i = 0; i < 5; i++) send_point(any24(), any24());
      hold_left = 3000;
      for (int i = 0; i < 8; i++) send_pose(any24(), any24(), any16());
      wait_idle();
   endtask

   task automatic random_config(input longint span);
      longint stop;
      case ($urandom_range(5))
         0: write_config(0, 0, 0, 0);
         1: write_config(255, 65535, 23'h7FFFFF, 23'h7FFFFF);
         2: write_config(longint'($urandom), longint'($urandom), longint'($urandom),
                         longint'($urandom));
         default: begin
            stop = longint'($urandom_range(32'(span)));
            write_config(longint'($urandom_range(4)), longint'($urandom_range(65535)), stop,
                         ($urandom_range(9) == 0) ? longint'($urandom_range(32'(stop)))
                                                  : stop + longint'($urandom_range(
                                                       32'(4 * span))));
         end
      endcase
   endtask

   task automatic test_random(input int count);
      int stop_at, pts, poses, span, bx, by, pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         span = ($urandom_range(3) == 0) ? 8388607 : $urandom_range(1, 5000);
         bx = $signed(24'($urandom)) / 4;
         by = $signed(24'($urandom)) / 4;
         if (span == 8388607) begin
            bx = 0; by = 0;
         end
         if ($urandom_range(5) == 0) begin
            wait_idle();
            random_config(span);
         end
         send_clear();
         pts = ($urandom_range(39) == 0) ? $urandom_range(100, 256) : $urandom_range(0, 12);
         for (int i = 0; i < pts; i++)
            send_point(24'(bx + $signed($urandom_range(2 * span)) - span),
                       24'(by + $signed($urandom_range(2 * span)) - span));
         poses = $urandom_range(1, 6);
         for (int i = 0; i < poses; i++) begin
            pick = (pts > 0) ? $urandom_range(pts - 1) : 0;
            if ($urandom_range(9) == 0) begin
               if ($urandom_range(1)) send_item(MODE_UNUSED, any24(), any24(), any24(), any24(),
                                                any16());
               else send_point(any24(), any24());
            end
            if (pts > 0 && $urandom_range(3) != 0)
               send_pose(24'(path_x[pick] + $signed($urandom_range(2 * span)) - span),
                         24'(path_y[pick] + $signed($urandom_range(2 * span)) - span),
                         any16());
            else
               send_pose(any24(), any24(), any16());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_CLEAR;
      req_point_x = '0;
      req_point_y = '0;
      req_robot_x = '0;
      req_robot_y = '0;
      req_robot_yaw = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_AHEAD;
      csr_wdata = '0;
      path_len = 0;
      lookahead = 0;
      cruise_speed = 0;
      stop_dist = 0;
      slow_dist = 0;
      errors = 0;
      items_sent = 0;
      cmds_checked = 0;
      config_writes = 0;
      hold_left = 0;
      cycles = 0;
      send_idle = 35;
      recv_idle = 49;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_path();
      test_backpressure();
      test_random(350);
      wait_idle();
      send_idle = 49;
      recv_idle = 35;
      test_random(350);
      wait_idle();
      send_idle = 0;
      recv_idle = 0;
      test_random(350);
      wait_idle();
      $display("Sent %0d request transactions, checked %0d commands, %0d register writes.",
               items_sent, cmds_checked, config_writes);
      $display("Covered empty and full paths, ties, ramp and cruise speeds, and backpressure.");
      if (errors == 0 && pending_cmds.size() == 0) begin
         $display("pure_pursuit_velocity_command_top: match");
      end else begin
         $display("pure_pursuit_velocity_command_top: mismatch");
      end
      $finish;
   end

endmodule
